@@ hw/rtl/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Types and codes shared by the deframer, its channel interfaces and its
// configuration port.
// ----------------------------------------------------------------------------
package wsd_pkg;

   typedef logic [1:0] result_kind_type;
   typedef logic [2:0] status_type;
   typedef logic [3:0] opcode_type;
   typedef logic [7:0] byte_type;

   localparam result_kind_type RK_PAYLOAD = 2'd0;
   localparam result_kind_type RK_EMPTY   = 2'd1;
   localparam result_kind_type RK_ERROR   = 2'd2;

   localparam status_type ST_OK         = 3'd0;
   localparam status_type ST_END_HDR    = 3'd1;
   localparam status_type ST_RSV        = 3'd2;
   localparam status_type ST_BAD_CONT   = 3'd3;
   localparam status_type ST_MASK_CHG   = 3'd4;
   localparam status_type ST_END_EXT    = 3'd5;
   localparam status_type ST_TOO_BIG    = 3'd6;
   localparam status_type ST_END_PAYLD  = 3'd7;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam int SIZE_W = 31;

   localparam logic [SIZE_W-1:0] MAX_SIZE_RESET = 31'd67108864;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [3:0] KEY_BYTES   = 4'd4;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;

endpackage

@@ hw/rtl/wsd_req_if.sv @@
// ----------------------------------------------------------------------------
// Deframer input channel
// Carries one received byte or an end-of-stream event per transaction.
// ----------------------------------------------------------------------------
interface wsd_req_if;
   import wsd_pkg::*;

   logic     valid;
   logic     ready;
   logic     kind;
   byte_type rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink   (input valid, input kind, input rx_byte, output ready);

endinterface

@@ hw/rtl/wsd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Deframer result channel
// Carries one payload byte, message end or error report per transaction.
// ----------------------------------------------------------------------------
interface wsd_rsp_if;
   import wsd_pkg::*;

   logic            valid;
   logic            ready;
   result_kind_type result_kind;
   byte_type        payload_byte;
   logic            last_of_message;
   opcode_type      message_opcode;
   logic            compressed;
   logic            masked;
   status_type      status;

   modport source (output valid, output result_kind, output payload_byte,
                   output last_of_message, output message_opcode,
                   output compressed, output masked, output status,
                   input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input last_of_message, input message_opcode,
                   input compressed, input masked, input status,
                   output ready);

endinterface

@@ hw/rtl/websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses frame headers, unmasks payload bytes, joins fragments and checks
// the message total against a configurable limit.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Carries
//  ---------+-----------+---------------------------------------------------
//  req_chan | in        | received byte or end-of-stream event
//  rsp_chan | out       | payload byte, empty message end or error status
//  csr_*    | in/out    | APB-style access to max_message_size
//
// Each input transaction is decoded combinationally; the parser state and the
// result register are both loaded at the accepting edge.
// A new input transaction is accepted every cycle unless a result is held
// in the output register while the result channel stalls.
// Reset is synchronous; it returns the parser to idle and restores the
// message size limit to 64 MiB.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
   input  logic                      clock,
   input  logic                      reset,
   wsd_req_if.sink                   req_chan,
   wsd_rsp_if.source                 rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [1:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import wsd_pkg::*;

   localparam logic [1:0] PH_HDR0    = 2'd0;
   localparam logic [1:0] PH_HDR1    = 2'd1;
   localparam logic [1:0] PH_EXT     = 2'd2;
   localparam logic [1:0] PH_PAYLOAD = 2'd3;

   logic [SIZE_W-1:0] max_size_ff;

   logic [1:0]        phase_ff,   phase_in;
   logic [3:0]        hcount_ff,  hcount_in;
   logic [SIZE_W-1:0] remain_ff,  remain_in;
   logic              ovf_ff,     ovf_in;
   logic [SIZE_W-1:0] total_ff,   total_in;
   logic [31:0]       key_ff,     key_in;
   logic [1:0]        kidx_ff,    kidx_in;
   logic              frag_ff,    frag_in;
   logic              mask_ff,    mask_in;
   logic              fin_ff,     fin_in;
   opcode_type        opcode_ff,  opcode_in;
   logic              comp_ff,    comp_in;

   logic              rv_ff;
   result_kind_type   rk_ff,      rk_in;
   byte_type          pb_ff,      pb_in;
   logic              last_ff,    last_in;
   opcode_type        rop_ff,     rop_in;
   logic              rcomp_ff,   rcomp_in;
   logic              rmask_ff,   rmask_in;
   status_type        st_ff,      st_in;
   logic              emit;

   logic              accept;
   logic              do_fail;
   logic              do_begin;
   logic              do_clear;
   status_type        fail_st;
   logic [SIZE_W:0]   sum;
   logic [3:0]        hc_new;
   byte_type          b;
   byte_type          kb;
   logic [SIZE_W-1:0] rem_dec;

   assign req_chan.ready = !rv_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign b              = req_chan.rx_byte;

   assign csr_pready = 1'b1;
   assign csr_prdata = {1'b0, max_size_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= MAX_SIZE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         max_size_ff <= csr_pwdata[SIZE_W-1:0];
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      hcount_in = hcount_ff;
      remain_in = remain_ff;
      ovf_in    = ovf_ff;
      total_in  = total_ff;
      key_in    = key_ff;
      kidx_in   = kidx_ff;
      frag_in   = frag_ff;
      mask_in   = mask_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      comp_in   = comp_ff;
      emit      = 1'b0;
      rk_in     = RK_PAYLOAD;
      pb_in     = '0;
      last_in   = 1'b0;
      st_in     = ST_OK;
      do_fail   = 1'b0;
      do_begin  = 1'b0;
      do_clear  = 1'b0;
      fail_st   = ST_OK;
      hc_new    = '0;
      kb        = '0;
      rem_dec   = remain_ff - 1'b1;
      sum       = '0;

      if (req_chan.kind == KIND_END) begin
         do_fail = 1'b1;
         case (phase_ff)
            PH_EXT:     fail_st = ST_END_EXT;
            PH_PAYLOAD: fail_st = ST_END_PAYLD;
            default:    fail_st = ST_END_HDR;
         endcase
      end else begin
         case (phase_ff)
            PH_HDR0: begin
               if (b[5:4] != 2'b00) begin
                  do_fail = 1'b1;
                  fail_st = ST_RSV;
               end else if (frag_ff && (b[3:0] != 4'd0)) begin
                  do_fail = 1'b1;
                  fail_st = ST_BAD_CONT;
               end else begin
                  comp_in  = comp_ff | b[6];
                  fin_in   = b[7];
                  if (!frag_ff) begin
                     opcode_in = b[3:0];
                  end
                  phase_in = PH_HDR1;
               end
            end
            PH_HDR1: begin
               if (frag_ff && (b[7] != mask_ff)) begin
                  do_fail = 1'b1;
                  fail_st = ST_MASK_CHG;
               end else begin
                  mask_in = frag_ff ? mask_ff : b[7];
                  key_in  = '0;
                  ovf_in  = 1'b0;
                  hc_new  = mask_in ? KEY_BYTES : 4'd0;
                  if (b[6:0] == LEN_EXT16) begin
                     hc_new    = hc_new + EXT16_BYTES;
                     remain_in = '0;
                  end else if (b[6:0] == LEN_EXT64) begin
                     hc_new    = hc_new + EXT64_BYTES;
                     remain_in = '0;
                  end else begin
                     remain_in = {{(SIZE_W-7){1'b0}}, b[6:0]};
                  end
                  hcount_in = hc_new;
                  if (hc_new == 4'd0) begin
                     do_begin = 1'b1;
                  end else begin
                     phase_in = PH_EXT;
                  end
               end
            end
            PH_EXT: begin
               if (hcount_ff > (mask_ff ? KEY_BYTES : 4'd0)) begin
                  remain_in = {remain_ff[SIZE_W-9:0], b};
                  ovf_in    = ovf_ff | (remain_ff[SIZE_W-1:SIZE_W-8] != 8'd0);
               end else begin
                  key_in = {key_ff[23:0], b};
               end
               hc_new    = (hcount_ff != 4'd0) ? hcount_ff - 4'd1 : 4'd0;
               hcount_in = hc_new;
               if (hc_new == 4'd0) begin
                  do_begin = 1'b1;
               end
            end
            default: begin
               case (kidx_ff)
                  2'd0:    kb = key_ff[31:24];
                  2'd1:    kb = key_ff[23:16];
                  2'd2:    kb = key_ff[15:8];
                  default: kb = key_ff[7:0];
               endcase
               kidx_in   = kidx_ff + 2'd1;
               remain_in = rem_dec;
               emit      = 1'b1;
               rk_in     = RK_PAYLOAD;
               pb_in     = b ^ kb;
               if (rem_dec == '0) begin
                  last_in = fin_ff;
                  if (fin_ff) begin
                     do_clear = 1'b1;
                  end else begin
                     frag_in  = 1'b1;
                     key_in   = '0;
                     phase_in = PH_HDR0;
                  end
               end
            end
         endcase
      end

      if (do_begin) begin
         sum = {1'b0, total_ff} + {1'b0, remain_in};
         if (ovf_in || (sum > {1'b0, max_size_ff})) begin
            do_fail = 1'b1;
            fail_st = ST_TOO_BIG;
         end else begin
            total_in = sum[SIZE_W-1:0];
            kidx_in  = 2'd0;
            if (remain_in != '0) begin
               phase_in = PH_PAYLOAD;
            end else if (fin_in) begin
               emit     = 1'b1;
               rk_in    = RK_EMPTY;
               last_in  = 1'b1;
               do_clear = 1'b1;
            end else begin
               frag_in  = 1'b1;
               key_in   = '0;
               phase_in = PH_HDR0;
            end
         end
      end

      rop_in   = opcode_in;
      rcomp_in = comp_in;
      rmask_in = mask_in;

      if (do_fail) begin
         emit     = 1'b1;
         rk_in    = RK_ERROR;
         pb_in    = '0;
         last_in  = 1'b0;
         st_in    = fail_st;
         rop_in   = '0;
         rcomp_in = 1'b0;
         rmask_in = 1'b0;
         do_clear = 1'b1;
      end

      if (do_clear) begin
         phase_in  = PH_HDR0;
         hcount_in = '0;
         remain_in = '0;
         ovf_in    = 1'b0;
         total_in  = '0;
         key_in    = '0;
         kidx_in   = '0;
         frag_in   = 1'b0;
         mask_in   = 1'b0;
         fin_in    = 1'b0;
         opcode_in = '0;
         comp_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         hcount_ff <= '0;
         remain_ff <= '0;
         ovf_ff    <= 1'b0;
         total_ff  <= '0;
         key_ff    <= '0;
         kidx_ff   <= '0;
         frag_ff   <= 1'b0;
         mask_ff   <= 1'b0;
         fin_ff    <= 1'b0;
         opcode_ff <= '0;
         comp_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         hcount_ff <= hcount_in;
         remain_ff <= remain_in;
         ovf_ff    <= ovf_in;
         total_ff  <= total_in;
         key_ff    <= key_in;
         kidx_ff   <= kidx_in;
         frag_ff   <= frag_in;
         mask_ff   <= mask_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         comp_ff   <= comp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (accept) begin
         rv_ff <= emit;
      end else if (rsp_chan.ready) begin
         rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rk_ff    <= rk_in;
         pb_ff    <= pb_in;
         last_ff  <= last_in;
         rop_ff   <= rop_in;
         rcomp_ff <= rcomp_in;
         rmask_ff <= rmask_in;
         st_ff    <= st_in;
      end
   end

   assign rsp_chan.valid           = rv_ff;
   assign rsp_chan.result_kind     = rk_ff;
   assign rsp_chan.payload_byte    = pb_ff;
   assign rsp_chan.last_of_message = last_ff;
   assign rsp_chan.message_opcode  = rop_ff;
   assign rsp_chan.compressed      = rcomp_ff;
   assign rsp_chan.masked          = rmask_ff;
   assign rsp_chan.status          = st_ff;

   logic unused_csr;
   assign unused_csr = ^{csr_paddr, csr_pwdata[31]};

endmodule

@@ dv/wsd_deframe_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deframer result prediction and comparison
// Watches the input channel, the result channel and the register port of the
// deframer. It keeps its own copy of the parser state and of the message size
// limit, predicts the result of every accepted input transaction and compares
// each delivered result field by field with the oldest prediction. Register
// reads are checked against the limit held here.
// ----------------------------------------------------------------------------
module wsd_deframe_check #(
   parameter logic [1:0] SIZE_REG_ADDR = 2'd0
) (
   input  logic        clock,
   input  logic        reset,
   wsd_req_if          req_chan,
   wsd_rsp_if          rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   output int          fail_count,
   output int          due_count,
   output int          result_count,
   output int          error_count
);
   import wsd_pkg::*;

   localparam int PRINT_LIMIT = 40;

   typedef enum logic [1:0] {
      PARSE_HDR0,
      PARSE_HDR1,
      PARSE_EXT,
      PARSE_PAYLOAD
   } parse_phase_type;

   typedef struct packed {
      result_kind_type kind;
      byte_type        data;
      logic            last;
      opcode_type      opcode;
      logic            compressed;
      logic            masked;
      status_type      status;
   } deframe_result_type;

   logic [SIZE_W-1:0]  size_limit;
   parse_phase_type    parse_phase;
   logic [3:0]         hdr_left;
   logic [63:0]        frame_left;
   logic [63:0]        msg_total;
   logic [31:0]        mask_key;
   logic [1:0]         key_pos;
   logic               in_fragment;
   logic               msg_masked;
   logic               frame_final;
   logic               msg_compressed;
   opcode_type         msg_opcode;

   deframe_result_type deframed_due[$];

   task automatic report_mismatch(input string what, input logic [63:0] seen,
                                  input logic [63:0] want);
      if (fail_count < PRINT_LIMIT)
         $display("MISMATCH at %0t ns: %s is %0h, expected %0h", $time, what, seen, want);
      fail_count++;
   endtask

   function void clear_message();
      parse_phase    = PARSE_HDR0;
      hdr_left       = '0;
      frame_left     = '0;
      msg_total      = '0;
      mask_key       = '0;
      key_pos        = '0;
      in_fragment    = 1'b0;
      msg_masked     = 1'b0;
      frame_final    = 1'b0;
      msg_compressed = 1'b0;
      msg_opcode     = '0;
   endfunction

   function void emit(input result_kind_type kind, input byte_type data, input logic last,
                      input status_type status);
      deframe_result_type r;
      r.kind   = kind;
      r.data   = data;
      r.last   = last;
      r.status = status;
      if (kind == RK_ERROR) begin
         r.opcode     = '0;
         r.compressed = 1'b0;
         r.masked     = 1'b0;
      end else begin
         r.opcode     = msg_opcode;
         r.compressed = msg_compressed;
         r.masked     = msg_masked;
      end
      deframed_due.push_back(r);
   endfunction

   function void raise_error(input status_type status);
      emit(RK_ERROR, '0, 1'b0, status);
      clear_message();
   endfunction

   // The size check happens once the whole header of a frame is in.
   function void close_header();
      logic [63:0] room;
      room = {33'd0, size_limit} - msg_total;
      if (msg_total > {33'd0, size_limit} || frame_left > room) begin
         raise_error(ST_TOO_BIG);
      end else begin
         msg_total = msg_total + frame_left;
         key_pos   = '0;
         if (frame_left != 0) begin
            parse_phase = PARSE_PAYLOAD;
         end else if (frame_final) begin
            emit(RK_EMPTY, '0, 1'b1, ST_OK);
            clear_message();
         end else begin
            in_fragment = 1'b1;
            mask_key    = '0;
            parse_phase = PARSE_HDR0;
         end
      end
   endfunction

   function void parse_stream_item(input logic kind, input byte_type b);
      byte_type   key_byte;
      logic [3:0] key_len;
      if (kind == KIND_END) begin
         case (parse_phase)
            PARSE_EXT:     raise_error(ST_END_EXT);
            PARSE_PAYLOAD: raise_error(ST_END_PAYLD);
            default:       raise_error(ST_END_HDR);
         endcase
      end else begin
         case (parse_phase)
            PARSE_HDR0: begin
               if (b[5:4] != 2'b00) begin
                  raise_error(ST_RSV);
               end else begin
                  if (b[6])
                     msg_compressed = 1'b1;
                  frame_final = b[7];
                  if (in_fragment && b[3:0] != 4'd0) begin
                     raise_error(ST_BAD_CONT);
                  end else begin
                     if (!in_fragment)
                        msg_opcode = b[3:0];
                     parse_phase = PARSE_HDR1;
                  end
               end
            end
            PARSE_HDR1: begin
               if (in_fragment && b[7] != msg_masked) begin
                  raise_error(ST_MASK_CHG);
               end else begin
                  if (!in_fragment)
                     msg_masked = b[7];
                  mask_key = '0;
                  hdr_left = msg_masked ? KEY_BYTES : 4'd0;
                  if (b[6:0] == LEN_EXT16) begin
                     hdr_left   = hdr_left + EXT16_BYTES;
                     frame_left = '0;
                  end else if (b[6:0] == LEN_EXT64) begin
                     hdr_left   = hdr_left + EXT64_BYTES;
                     frame_left = '0;
                  end else begin
                     frame_left = {57'd0, b[6:0]};
                  end
                  if (hdr_left == 0)
                     close_header();
                  else
                     parse_phase = PARSE_EXT;
               end
            end
            PARSE_EXT: begin
               key_len = msg_masked ? KEY_BYTES : 4'd0;
               if (hdr_left > key_len)
                  frame_left = {frame_left[55:0], b};
               else
                  mask_key = {mask_key[23:0], b};
               if (hdr_left != 0)
                  hdr_left = hdr_left - 4'd1;
               if (hdr_left == 0)
                  close_header();
            end
            default: begin
               key_byte = mask_key[31 - 8 * key_pos -: 8];
               key_pos  = key_pos + 2'd1;
               if (frame_left != 0)
                  frame_left = frame_left - 64'd1;
               if (frame_left == 0) begin
                  if (frame_final) begin
                     emit(RK_PAYLOAD, b ^ key_byte, 1'b1, ST_OK);
                     clear_message();
                  end else begin
                     emit(RK_PAYLOAD, b ^ key_byte, 1'b0, ST_OK);
                     in_fragment = 1'b1;
                     mask_key    = '0;
                     parse_phase = PARSE_HDR0;
                  end
               end else begin
                  emit(RK_PAYLOAD, b ^ key_byte, 1'b0, ST_OK);
               end
            end
         endcase
      end
   endfunction

   always @(posedge clock) begin
      deframe_result_type seen;
      deframe_result_type want;
      if (reset) begin
         size_limit = MAX_SIZE_RESET;
         clear_message();
         deframed_due.delete();
         fail_count   = 0;
         result_count = 0;
         error_count  = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == SIZE_REG_ADDR) begin
            if (csr_pwrite)
               size_limit = csr_pwdata[SIZE_W-1:0];
            else if (csr_prdata !== {1'b0, size_limit})
               report_mismatch("max_message_size readback", csr_prdata, {1'b0, size_limit});
         end
         if (req_chan.valid && req_chan.ready)
            parse_stream_item(req_chan.kind, req_chan.rx_byte);
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.kind       = rsp_chan.result_kind;
            seen.data       = rsp_chan.payload_byte;
            seen.last       = rsp_chan.last_of_message;
            seen.opcode     = rsp_chan.message_opcode;
            seen.compressed = rsp_chan.compressed;
            seen.masked     = rsp_chan.masked;
            seen.status     = rsp_chan.status;
            result_count++;
            if (deframed_due.size() == 0) begin
               report_mismatch("unexpected result transaction", seen, '0);
            end else begin
               want = deframed_due.pop_front();
               if (want.kind == RK_ERROR)
                  error_count++;
               if (seen.kind !== want.kind)
                  report_mismatch("result_kind", seen.kind, want.kind);
               if (seen.data !== want.data)
                  report_mismatch("payload_byte", seen.data, want.data);
               if (seen.last !== want.last)
                  report_mismatch("last_of_message", seen.last, want.last);
               if (seen.opcode !== want.opcode)
                  report_mismatch("message_opcode", seen.opcode, want.opcode);
               if (seen.compressed !== want.compressed)
                  report_mismatch("compressed", seen.compressed, want.compressed);
               if (seen.masked !== want.masked)
                  report_mismatch("masked", seen.masked, want.masked);
               if (seen.status !== want.status)
                  report_mismatch("status", seen.status, want.status);
            end
         end
      end
      due_count = deframed_due.size();
   end

endmodule

@@ dv/tb_websocket_frame_deframer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Resets the deframer once, then feeds it a short directed stream covering
// every error status but ST_TOO_BIG, empty frames and fragmentation, followed by random
// messages built from well-formed frames with occasional faults, truncations
// and noise. The message size limit is changed between phases, and both
// channels idle and stall at varying rates. Results are checked by a
// separate prediction module; this module drives stimulus and gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer;
   import wsd_pkg::*;

   localparam logic [1:0] REG_MAX_SIZE    = 2'd0;
   localparam opcode_type OP_CONTINUATION = 4'h0;
   localparam int         STALL_LIMIT     = 2000;
   localparam int         HOLD_CYCLES     = 300;
   localparam int         DRAIN_CYCLES    = 8;

   typedef enum {
      FAULT_NONE,
      FAULT_RSV,
      FAULT_OPCODE,
      FAULT_MASK,
      FAULT_CUT,
      FAULT_HUGE
   } fault_kind_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          send_idle_pct;
   int          recv_idle_pct;
   bit          hold_req;
   int          sent_count;
   int          frame_count;
   int          quiet_cycles;
   int          fail_count;
   int          due_count;
   int          result_count;
   int          error_count;

   wsd_req_if req_chan ();
   wsd_rsp_if rsp_chan ();

   websocket_frame_deframer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   wsd_deframe_check #(.SIZE_REG_ADDR(REG_MAX_SIZE)) check_unit (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_pready   (csr_pready),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .fail_count   (fail_count),
      .due_count    (due_count),
      .result_count (result_count),
      .error_count  (error_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The receiver stalls at random, or for a long stretch when asked to.
   initial begin
      int hold_left;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic kind, input byte_type data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.kind    <= kind;
      req_chan.rx_byte <= data;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [1:0] addr,
                             input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // The sender stops until every predicted result has been delivered; an
   // empty non-final frame leaves no result behind, hence the extra cycles.
   task automatic settle();
      req_chan.valid <= 1'b0;
      wait (due_count == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_size_limit(input logic [31:0] limit);
      settle();
      csr_access(1'b1, REG_MAX_SIZE, limit);
      csr_access(1'b0, REG_MAX_SIZE, '0);
   endtask

   function automatic void add_frame(ref byte_type q[$], input logic fin, input logic [2:0] rsv,
                                     input opcode_type op, input logic msk,
                                     input logic [63:0] flen, input int form,
                                     input int n_payload);
      logic [31:0] key;
      key = $urandom;
      frame_count++;
      q.push_back({fin, rsv, op});
      case (form)
         0: q.push_back({msk, flen[6:0]});
         1: begin
            q.push_back({msk, LEN_EXT16});
            q.push_back(flen[15:8]);
            q.push_back(flen[7:0]);
         end
         default: begin
            q.push_back({msk, LEN_EXT64});
            for (int i = 7; i >= 0; i--)
               q.push_back(flen[8 * i +: 8]);
         end
      endcase
      if (msk) begin
         for (int i = 3; i >= 0; i--)
            q.push_back(key[8 * i +: 8]);
      end
      for (int i = 0; i < n_payload; i++)
         q.push_back(byte_type'($urandom_range(255)));
   endfunction

   task automatic send_message();
      byte_type       q[$];
      fault_kind_type fault;
      int             n_frames;
      int             bad_frame;
      int             pick;
      int             form;
      int             cut;
      logic           msk;
      logic           frame_msk;
      logic [2:0]     rsv;
      opcode_type     op;
      logic [63:0]    flen;
      n_frames = ($urandom_range(2) == 0) ? $urandom_range(2, 3) : 1;
      msk      = $urandom_range(1);
      pick     = $urandom_range(99);
      if (pick < 72)
         fault = FAULT_NONE;
      else if (pick < 77)
         fault = FAULT_RSV;
      else if (pick < 82)
         fault = FAULT_OPCODE;
      else if (pick < 87)
         fault = FAULT_MASK;
      else if (pick < 95)
         fault = FAULT_CUT;
      else
         fault = FAULT_HUGE;
      if ((fault == FAULT_OPCODE || fault == FAULT_MASK) && n_frames < 2)
         n_frames = 2;
      if (fault == FAULT_OPCODE || fault == FAULT_MASK)
         bad_frame = $urandom_range(1, n_frames - 1);
      else
         bad_frame = $urandom_range(0, n_frames - 1);
      for (int f = 0; f < n_frames; f++) begin
         rsv       = {($urandom_range(3) == 0), 2'b00};
         op        = (f == 0) ? opcode_type'($urandom_range(15)) : OP_CONTINUATION;
         frame_msk = msk;
         flen      = ($urandom_range(11) == 0) ? 64'd125 : 64'($urandom_range(12));
         pick      = $urandom_range(9);
         form      = (pick < 7) ? 0 : (pick < 9) ? 1 : 2;
         if (f == bad_frame) begin
            case (fault)
               FAULT_RSV:    rsv[1:0] = 2'($urandom_range(1, 3));
               FAULT_OPCODE: op = opcode_type'($urandom_range(1, 15));
               FAULT_MASK:   frame_msk = ~msk;
               FAULT_HUGE: begin
                  flen = {1'b1, 31'($urandom), 32'($urandom)};
                  form = 2;
               end
               default: ;
            endcase
         end
         add_frame(q, (f == n_frames - 1), rsv, op, frame_msk, flen, form,
                   (fault == FAULT_HUGE && f == bad_frame) ? 0 : int'(flen));
         if (f == bad_frame && fault != FAULT_NONE && fault != FAULT_CUT)
            break;
      end
      if (fault == FAULT_CUT) begin
         cut = $urandom_range(0, q.size() - 1);
         while (q.size() > cut)
            void'(q.pop_back());
      end
      foreach (q[i])
         send_item(KIND_BYTE, q[i]);
      if (fault == FAULT_CUT)
         send_item(KIND_END, byte_type'($urandom_range(255)));
   endtask

   // Stray bytes are always followed by an end of stream, which brings the
   // parser back to idle whatever they started.
   task automatic send_noise();
      repeat ($urandom_range(1, 3))
         send_item(KIND_BYTE, byte_type'($urandom_range(255)));
      send_item(KIND_END, byte_type'($urandom_range(255)));
   endtask

   task automatic run_random(input int n_items);
      int target;
      target = sent_count + n_items;
      while (sent_count < target) begin
         if ($urandom_range(9) == 0)
            send_noise();
         else
            send_message();
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.kind    = KIND_BYTE;
      req_chan.rx_byte = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      send_idle_pct    = 0;
      recv_idle_pct    = 0;
      hold_req         = 1'b0;
      sent_count       = 0;
      frame_count      = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_access(1'b0, REG_MAX_SIZE, '0);

      // End of stream at idle, a compressed one-byte message, reserved bits,
      // a bad continuation opcode, a mask change, ends in the extended header
      // and in the payload, and an empty final frame.
      send_item(KIND_END, 8'h00);
      send_item(KIND_BYTE, 8'hC1);
      send_item(KIND_BYTE, 8'h01);
      send_item(KIND_BYTE, 8'hAA);
      send_item(KIND_BYTE, 8'h70);
      send_item(KIND_BYTE, 8'h02);
      send_item(KIND_BYTE, 8'h00);
      send_item(KIND_BYTE, 8'h81);
      send_item(KIND_BYTE, 8'h02);
      send_item(KIND_BYTE, 8'h01);
      send_item(KIND_BYTE, 8'h55);
      send_item(KIND_BYTE, 8'h80);
      send_item(KIND_BYTE, 8'h80);
      send_item(KIND_BYTE, 8'h81);
      send_item(KIND_BYTE, 8'hFE);
      send_item(KIND_BYTE, 8'h00);
      send_item(KIND_END, 8'hFF);
      send_item(KIND_BYTE, 8'h82);
      send_item(KIND_BYTE, 8'h03);
      send_item(KIND_BYTE, 8'h01);
      send_item(KIND_END, 8'h00);
      send_item(KIND_BYTE, 8'h89);
      send_item(KIND_BYTE, 8'h00);

      send_idle_pct = 22;
      recv_idle_pct = 82;
      hold_req      = 1'b1;
      run_random(220);

      set_size_limit(32'd20);
      send_idle_pct = 82;
      recv_idle_pct = 22;
      run_random(110);
      settle();
      run_random(110);

      set_size_limit(32'hFFFF_FFFF);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req      = 1'b1;
      run_random(120);

      set_size_limit(32'd0);
      run_random(60);
      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d stream transactions carrying %0d generated frames.",
               sent_count, frame_count);
      $display("Compared %0d results, %0d of them error reports, under four size limits.",
               result_count, error_count);
      if (fail_count == 0 && due_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
